/* src/rc4_pkg.sv */
// Package for the RC4 stream cipher: codes, microcode word types and the control store.
package rc4_pkg;

   localparam int TableEntries = 256;
   localparam int ByteWidth    = 8;
   localparam int KeyLenWidth  = 9;
   localparam int PcWidth      = 5;

   typedef logic [ByteWidth-1:0]   byte_type;
   typedef logic [KeyLenWidth-1:0] klen_type;
   typedef logic [PcWidth-1:0]     pc_type;
   typedef logic [1:0]             func_type;

   localparam func_type FUNC_KEY    = 2'd0;
   localparam func_type FUNC_CRYPT  = 2'd1;
   localparam func_type FUNC_STREAM = 2'd2;

   localparam klen_type KEY_LEN_MAX = klen_type'(TableEntries);
   localparam byte_type BYTE_LAST   = byte_type'(TableEntries - 1);

   // Control store addresses
   localparam pc_type STEP_RINIT  = 5'd0;
   localparam pc_type STEP_FETCH  = 5'd1;
   localparam pc_type STEP_KEY    = 5'd2;
   localparam pc_type STEP_INIT   = 5'd3;
   localparam pc_type STEP_SETUP  = 5'd4;
   localparam pc_type STEP_S_RDN  = 5'd5;
   localparam pc_type STEP_S_ACC  = 5'd6;
   localparam pc_type STEP_S_RDJ  = 5'd7;
   localparam pc_type STEP_S_WRN  = 5'd8;
   localparam pc_type STEP_S_WRJ  = 5'd9;
   localparam pc_type STEP_S_DONE = 5'd10;
   localparam pc_type STEP_G_INCI = 5'd11;
   localparam pc_type STEP_G_RDI  = 5'd12;
   localparam pc_type STEP_G_ACC  = 5'd13;
   localparam pc_type STEP_G_RDJ  = 5'd14;
   localparam pc_type STEP_G_WRI  = 5'd15;
   localparam pc_type STEP_G_WRJ  = 5'd16;
   localparam pc_type STEP_G_RDT  = 5'd17;
   localparam pc_type STEP_G_EMIT = 5'd18;

   typedef enum logic [1:0] {
      ADDR_N,
      ADDR_I,
      ADDR_J,
      ADDR_T
   } addr_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_N_IDENT,
      WR_N_RD,
      WR_I_RD,
      WR_J_HOLD
   } wr_sel_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_KEY_STORE,
      OP_N_INC,
      OP_SETUP,
      OP_SCHED_J,
      OP_SCHED_NEXT,
      OP_SCHED_DONE,
      OP_I_INC,
      OP_GEN_J,
      OP_GEN_SJ,
      OP_EMIT
   } dp_op_type;

   typedef enum logic [2:0] {
      JMP_NEXT,
      JMP_GOTO,
      JMP_DISPATCH,
      JMP_LAST,
      JMP_LOOP,
      JMP_WAIT
   } jump_type;

   typedef struct packed {
      logic         ready;
      addr_sel_type addr_sel;
      wr_sel_type   wr_sel;
      dp_op_type    op;
      jump_type     jump;
      pc_type       target;
   } ctrl_word_type;

   typedef struct packed {
      logic     accept;
      func_type req_func;
      logic     last;
      logic     n_end;
      logic     out_busy;
   } status_type;

   function automatic ctrl_word_type ucode_rom(input pc_type pc);
      ctrl_word_type w;
      w = '{ready: 1'b0, addr_sel: ADDR_N, wr_sel: WR_NONE, op: OP_NONE,
            jump: JMP_NEXT, target: STEP_FETCH};
      unique case (pc)
         STEP_RINIT: begin
            w.wr_sel = WR_N_IDENT; w.op = OP_N_INC;
            w.jump = JMP_LOOP; w.target = STEP_RINIT;
         end
         STEP_FETCH: begin
            w.ready = 1'b1; w.jump = JMP_DISPATCH;
         end
         STEP_KEY: begin
            w.op = OP_KEY_STORE; w.jump = JMP_LAST; w.target = STEP_INIT;
         end
         STEP_INIT: begin
            w.wr_sel = WR_N_IDENT; w.op = OP_N_INC;
            w.jump = JMP_LOOP; w.target = STEP_INIT;
         end
         STEP_SETUP:  w.op = OP_SETUP;
         STEP_S_RDN:  w.addr_sel = ADDR_N;
         STEP_S_ACC:  w.op = OP_SCHED_J;
         STEP_S_RDJ:  w.addr_sel = ADDR_J;
         STEP_S_WRN:  w.wr_sel = WR_N_RD;
         STEP_S_WRJ: begin
            w.wr_sel = WR_J_HOLD; w.op = OP_SCHED_NEXT;
            w.jump = JMP_LOOP; w.target = STEP_S_RDN;
         end
         STEP_S_DONE: begin
            w.op = OP_SCHED_DONE; w.jump = JMP_GOTO; w.target = STEP_FETCH;
         end
         STEP_G_INCI: w.op = OP_I_INC;
         STEP_G_RDI:  w.addr_sel = ADDR_I;
         STEP_G_ACC:  w.op = OP_GEN_J;
         STEP_G_RDJ:  w.addr_sel = ADDR_J;
         STEP_G_WRI: begin
            w.wr_sel = WR_I_RD; w.op = OP_GEN_SJ;
         end
         STEP_G_WRJ:  w.wr_sel = WR_J_HOLD;
         STEP_G_RDT:  w.addr_sel = ADDR_T;
         STEP_G_EMIT: begin
            // keep reading S[S[i]+S[j]] while the response register is busy
            w.addr_sel = ADDR_T;
            w.op = OP_EMIT; w.jump = JMP_WAIT; w.target = STEP_FETCH;
         end
         default: begin
            w.jump = JMP_GOTO; w.target = STEP_FETCH;
         end
      endcase
      return w;
   endfunction

endpackage

/* src/rc4_if.sv */
// Request and response channel interfaces for the RC4 stream cipher.
interface rc4_req_if import rc4_pkg::*;;
   logic     valid;
   logic     ready;
   func_type func;
   byte_type data_byte;
   logic     last;

   modport source (output valid, output func, output data_byte, output last, input ready);
   modport sink (input valid, input func, input data_byte, input last, output ready);
endinterface

interface rc4_rsp_if import rc4_pkg::*;;
   logic     valid;
   logic     ready;
   byte_type out_byte;

   modport source (output valid, output out_byte, input ready);
   modport sink (input valid, input out_byte, output ready);
endinterface

/* src/rc4_seq.sv */
// Microcode sequencer: step counter, control store lookup and jump logic.
module rc4_seq import rc4_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  status_type    status,
   output ctrl_word_type ctrl
);

   pc_type pc_ff;
   pc_type pc_in;

   always_comb begin
      ctrl = ucode_rom(pc_ff);
   end

   always_comb begin
      pc_in = pc_ff + pc_type'(1);
      unique case (ctrl.jump)
         JMP_NEXT: pc_in = pc_ff + pc_type'(1);
         JMP_GOTO: pc_in = ctrl.target;
         JMP_DISPATCH: begin
            if (!status.accept) begin
               pc_in = pc_ff;
            end else if (status.req_func == FUNC_KEY) begin
               pc_in = STEP_KEY;
            end else if (status.req_func == FUNC_CRYPT || status.req_func == FUNC_STREAM) begin
               pc_in = STEP_G_INCI;
            end else begin
               pc_in = STEP_FETCH;
            end
         end
         JMP_LAST: pc_in = status.last ? ctrl.target : STEP_FETCH;
         JMP_LOOP: pc_in = status.n_end ? pc_ff + pc_type'(1) : ctrl.target;
         JMP_WAIT: pc_in = status.out_busy ? pc_ff : ctrl.target;
         default:  pc_in = STEP_FETCH;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_RINIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   a_accept_at_fetch: assert property (@(posedge clock) disable iff (reset)
      status.accept |-> pc_ff == STEP_FETCH)
      else $error("request accepted outside fetch step");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= STEP_G_EMIT)
      else $error("step counter out of range");

   a_last_starts_schedule: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == STEP_KEY && status.last) |=> pc_ff == STEP_INIT)
      else $error("final key byte did not start key schedule");

endmodule

/* src/rc4_dpath.sv */
// Datapath: permutation and key memories, indices, holding registers and response register.
module rc4_dpath import rc4_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_word_type ctrl,
   output status_type    status,
   rc4_req_if.sink       req_chan,
   rc4_rsp_if.source     rsp_chan
);

   byte_type perm_mem [TableEntries];
   byte_type key_mem [TableEntries];

   byte_type perm_rd_ff;
   byte_type key_rd_ff;
   byte_type i_ff, i_in;
   byte_type j_ff, j_in;
   byte_type n_ff, n_in;
   byte_type k_ff, k_in;
   klen_type klen_ff, klen_in;
   byte_type hold_ff, hold_in;
   byte_type sj_ff, sj_in;
   func_type func_ff;
   byte_type data_ff;
   logic     last_ff;
   logic     rsp_valid_ff, rsp_valid_in;
   byte_type rsp_byte_ff, rsp_byte_in;

   logic     accept;
   logic     out_busy;
   logic     emit;
   logic     key_wr;
   logic     wr_en;
   byte_type wr_addr;
   byte_type wr_data;
   byte_type rd_addr;
   byte_type data_mask;

   assign accept      = req_chan.valid & ctrl.ready;
   assign req_chan.ready = ctrl.ready;
   assign out_busy    = rsp_valid_ff & ~rsp_chan.ready;
   assign emit        = (ctrl.op == OP_EMIT) & ~out_busy;
   assign key_wr      = (ctrl.op == OP_KEY_STORE) & (klen_ff < KEY_LEN_MAX);

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;

   assign status = '{accept: accept, req_func: req_chan.func, last: last_ff,
                     n_end: n_ff == BYTE_LAST, out_busy: out_busy};

   always_comb begin
      unique case (ctrl.addr_sel)
         ADDR_N:  rd_addr = n_ff;
         ADDR_I:  rd_addr = i_ff;
         ADDR_J:  rd_addr = j_ff;
         ADDR_T:  rd_addr = hold_ff + sj_ff;
         default: rd_addr = n_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = n_ff;
      wr_data = n_ff;
      unique case (ctrl.wr_sel)
         WR_NONE:    wr_en = 1'b0;
         WR_N_IDENT: begin
            wr_addr = n_ff; wr_data = n_ff;
         end
         WR_N_RD: begin
            wr_addr = n_ff; wr_data = perm_rd_ff;
         end
         WR_I_RD: begin
            wr_addr = i_ff; wr_data = perm_rd_ff;
         end
         WR_J_HOLD: begin
            wr_addr = j_ff; wr_data = hold_ff;
         end
         default:    wr_en = 1'b0;
      endcase
   end

   always_comb begin
      i_in        = i_ff;
      j_in        = j_ff;
      n_in        = n_ff;
      k_in        = k_ff;
      klen_in     = klen_ff;
      hold_in     = hold_ff;
      sj_in       = sj_ff;
      data_mask   = (func_ff == FUNC_CRYPT) ? data_ff : '0;
      rsp_byte_in = rsp_byte_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      unique case (ctrl.op)
         OP_NONE: ;
         OP_KEY_STORE: begin
            if (key_wr) begin
               klen_in = klen_ff + klen_type'(1);
            end
         end
         OP_N_INC: n_in = n_ff + byte_type'(1);
         OP_SETUP: begin
            i_in = '0;
            j_in = '0;
            k_in = '0;
         end
         OP_SCHED_J: begin
            hold_in = perm_rd_ff;
            j_in    = j_ff + key_rd_ff + perm_rd_ff;
         end
         OP_SCHED_NEXT: begin
            n_in = n_ff + byte_type'(1);
            k_in = ({1'b0, k_ff} + klen_type'(1) == klen_ff) ? '0 : k_ff + byte_type'(1);
         end
         OP_SCHED_DONE: begin
            klen_in = '0;
            j_in    = '0;
         end
         OP_I_INC: i_in = i_ff + byte_type'(1);
         OP_GEN_J: begin
            hold_in = perm_rd_ff;
            j_in    = j_ff + perm_rd_ff;
         end
         OP_GEN_SJ: sj_in = perm_rd_ff;
         OP_EMIT: begin
            if (emit) begin
               rsp_byte_in  = perm_rd_ff ^ data_mask;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         perm_mem[wr_addr] <= wr_data;
      end
      perm_rd_ff <= perm_mem[rd_addr];
      if (key_wr) begin
         key_mem[klen_ff[ByteWidth-1:0]] <= data_ff;
      end
      key_rd_ff <= key_mem[k_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff         <= '0;
         j_ff         <= '0;
         n_ff         <= '0;
         k_ff         <= '0;
         klen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         i_ff         <= i_in;
         j_ff         <= j_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         klen_ff      <= klen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff     <= hold_in;
      sj_ff       <= sj_in;
      rsp_byte_ff <= rsp_byte_in;
      if (accept) begin
         func_ff <= req_chan.func;
         data_ff <= req_chan.data_byte;
         last_ff <= req_chan.last;
      end
   end

   a_klen_bound: assert property (@(posedge clock) disable iff (reset)
      klen_ff <= KEY_LEN_MAX)
      else $error("key length above table size");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff && rsp_byte_ff == $past(perm_rd_ff ^ data_mask))
      else $error("emitted byte not presented");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> rsp_valid_ff && $stable(rsp_byte_ff))
      else $error("response changed while waiting");

endmodule

/* src/rc4_stream_cipher.sv */
// Top level of the RC4 stream cipher: microcode sequencer plus datapath.
//
//   channel   dir  fields                       handshake
//   req_chan  in   func, data_byte, last        valid/ready
//   rsp_chan  out  out_byte                     valid/ready
//
// A key byte request stores the byte. The final key byte adds the key schedule:
// an identity fill, then per entry read S[n], add to j, read S[j], write S[n], write S[j].
// A crypt or stream request runs the dependent reads of S[i], S[j], S[S[i]+S[j]] in turn.
// After reset an identity fill of the table runs before the first request is taken.
// A waiting response does not block the next request; only the emit step stalls on it.
module rc4_stream_cipher import rc4_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rc4_req_if.sink   req_chan,
   rc4_rsp_if.source rsp_chan
);

   ctrl_word_type ctrl;
   status_type    status;

   rc4_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   rc4_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .status   (status),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

/* verif/tb_top.sv */
// Testbench for rc4_stream_cipher: directed vectors plus random key and data traffic.
module tb_top;
   import rc4_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam func_type FUNC_UNUSED   = 2'd3;
   localparam int       DirectedCount = 23;
   localparam int       RandomItems   = 950;
   localparam int       CycleLimit    = 1000000;
   localparam int       DrainCycles   = 2000;

   typedef struct {
      func_type func;
      byte_type data_byte;
      logic     last;
      bit       fixed;
      byte_type fixed_out;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rc4_req_if req_chan ();
   rc4_rsp_if rsp_chan ();

   rc4_stream_cipher i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #5 clock = ~clock;

   // keystream generator state
   byte_type perm_bytes [TableEntries];
   byte_type key_bytes [TableEntries];
   byte_type ks_i;
   byte_type ks_j;
   klen_type key_count;

   byte_type expected_bytes [$];
   stim_row_type directed_rows [DirectedCount];

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  req_count      = 0;
   int  key_req_count  = 0;
   int  sched_count    = 0;
   int  rsp_checked    = 0;
   bit  sender_calm    = 1'b0;

   function automatic bit cipher_step(input func_type f, input byte_type d, input logic l,
                                      output byte_type res);
      int       n;
      int       klen;
      byte_type acc;
      byte_type tmp;
      byte_type idx;
      byte_type ks;
      res = '0;
      case (f)
         FUNC_KEY: begin
            if (key_count < KEY_LEN_MAX) begin
               key_bytes[key_count[7:0]] = d;
               key_count = key_count + 1'b1;
            end
            if (l) begin
               klen = int'(key_count);
               for (n = 0; n < TableEntries; n++) perm_bytes[n] = byte_type'(n);
               ks_i = '0;
               ks_j = '0;
               acc  = '0;
               for (n = 0; n < TableEntries; n++) begin
                  acc = acc + key_bytes[n % klen] + perm_bytes[n];
                  tmp = perm_bytes[n];
                  perm_bytes[n] = perm_bytes[acc];
                  perm_bytes[acc] = tmp;
               end
               key_count = '0;
            end
            return 1'b0;
         end
         FUNC_CRYPT, FUNC_STREAM: begin
            ks_i = ks_i + 1'b1;
            ks_j = ks_j + perm_bytes[ks_i];
            tmp = perm_bytes[ks_i];
            perm_bytes[ks_i] = perm_bytes[ks_j];
            perm_bytes[ks_j] = tmp;
            idx = perm_bytes[ks_i] + perm_bytes[ks_j];
            ks = perm_bytes[idx];
            res = (f == FUNC_CRYPT) ? (d ^ ks) : ks;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic send_request(input func_type f, input byte_type d, input logic l,
                               input bit has_fixed, input byte_type fixed_out);
      int       gap;
      byte_type res;
      bit       gives;
      gap = sender_calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.func      <= f;
      req_chan.data_byte <= d;
      req_chan.last      <= l;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      gives = cipher_step(f, d, l, res);
      if (gives) expected_bytes.push_back(has_fixed ? fixed_out : res);
      if (f != FUNC_UNUSED) req_count++;
      if (f == FUNC_KEY) key_req_count++;
      if (f == FUNC_KEY && l) sched_count++;
   endtask

   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_bytes.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // response side: random stalls, check against oldest expectation
   initial begin
      int       stall;
      bit       rsp_calm;
      byte_type want;
      rsp_chan.ready = 1'b0;
      rsp_calm = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_checked % 40 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
         stall = rsp_calm ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         if (expected_bytes.size() == 0) begin
            $error("out_byte: unexpected response %02h with nothing expected",
                   rsp_chan.out_byte);
            mismatch_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_chan.out_byte !== want) begin
               $error("out_byte: expected %02h, actual %02h", want, rsp_chan.out_byte);
               mismatch_count++;
            end
         end
         rsp_checked++;
      end
   end

   initial begin
      int       n;
      int       k;
      int       seq;
      int       kind;
      int       key_len;
      int       run_len;
      func_type f;
      logic     l;

      req_chan.valid     = 1'b0;
      req_chan.func      = FUNC_KEY;
      req_chan.data_byte = '0;
      req_chan.last      = 1'b0;

      for (n = 0; n < TableEntries; n++) begin
         perm_bytes[n] = byte_type'(n);
         key_bytes[n]  = '0;
      end
      ks_i = '0;
      ks_j = '0;
      key_count = '0;

      directed_rows = '{
         '{FUNC_STREAM, 8'h00, 1'b0, 1'b1, 8'h02},  // first byte off the reset table
         '{FUNC_CRYPT,  8'hFF, 1'b1, 1'b1, 8'hFA},  // last ignored on crypt
         '{FUNC_UNUSED, 8'hFF, 1'b1, 1'b0, 8'h00},
         '{FUNC_STREAM, 8'hFF, 1'b1, 1'b0, 8'h00},
         '{FUNC_UNUSED, 8'h00, 1'b0, 1'b0, 8'h00},
         '{FUNC_KEY,    8'h4B, 1'b0, 1'b0, 8'h00},  // key "Key"
         '{FUNC_KEY,    8'h65, 1'b0, 1'b0, 8'h00},
         '{FUNC_KEY,    8'h79, 1'b1, 1'b0, 8'h00},
         '{FUNC_CRYPT,  8'h50, 1'b0, 1'b1, 8'hBB},  // "Plaintext"
         '{FUNC_CRYPT,  8'h6C, 1'b0, 1'b1, 8'hF3},
         '{FUNC_CRYPT,  8'h61, 1'b0, 1'b1, 8'h16},
         '{FUNC_CRYPT,  8'h69, 1'b0, 1'b1, 8'hE8},
         '{FUNC_CRYPT,  8'h6E, 1'b0, 1'b1, 8'hD9},
         '{FUNC_CRYPT,  8'h74, 1'b0, 1'b1, 8'h40},
         '{FUNC_CRYPT,  8'h65, 1'b0, 1'b1, 8'hAF},
         '{FUNC_CRYPT,  8'h78, 1'b0, 1'b1, 8'h0A},
         '{FUNC_CRYPT,  8'h74, 1'b0, 1'b1, 8'hD3},
         '{FUNC_KEY,    8'h00, 1'b1, 1'b0, 8'h00},  // one-byte key of zero
         '{FUNC_CRYPT,  8'h00, 1'b0, 1'b0, 8'h00},
         '{FUNC_STREAM, 8'hFF, 1'b0, 1'b0, 8'h00},
         '{FUNC_KEY,    8'hFF, 1'b1, 1'b0, 8'h00},
         '{FUNC_CRYPT,  8'hFF, 1'b1, 1'b0, 8'h00},
         '{FUNC_STREAM, 8'h00, 1'b0, 1'b0, 8'h00}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < DirectedCount; n++) begin
         send_request(directed_rows[n].func, directed_rows[n].data_byte,
                      directed_rows[n].last, directed_rows[n].fixed,
                      directed_rows[n].fixed_out);
      end
      drain_responses();

      seq = 0;
      while (req_count < DirectedCount + RandomItems) begin
         sender_calm = ($urandom_range(0, 4) == 0);
         kind = $urandom_range(0, 9);
         if (seq == 2) key_len = $urandom_range(257, 270);
         else if (seq == 5) key_len = TableEntries;
         else key_len = $urandom_range(1, 16);
         if (seq == 2 || seq == 5) kind = 0;
         case (kind)
            7: begin
               run_len = $urandom_range(1, 8);
               for (k = 0; k < run_len; k++) begin
                  f = func_type'($urandom_range(0, 3));
                  l = (f == FUNC_KEY) ? ($urandom_range(0, 3) == 0) : 1'($urandom_range(0, 1));
                  send_request(f, byte_type'($urandom_range(0, 255)), l, 1'b0, 8'h00);
               end
            end
            default: begin
               if (kind == 9) drain_responses();
               if (kind == 8) key_len = $urandom_range(1, 6);
               for (k = 0; k < key_len; k++) begin
                  send_request(FUNC_KEY, byte_type'($urandom_range(0, 255)),
                               (kind != 8) && (k == key_len - 1), 1'b0, 8'h00);
               end
               run_len = $urandom_range(4, 30);
               for (k = 0; k < run_len; k++) begin
                  f = $urandom_range(0, 1) ? FUNC_CRYPT : FUNC_STREAM;
                  send_request(f, byte_type'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)), 1'b0, 8'h00);
               end
            end
         endcase
         seq++;
      end

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("run covered %0d requests in %0d sequences: %0d key bytes, %0d key schedules",
               req_count, seq, key_req_count, sched_count);
      $display("%0d keystream responses checked, %0d mismatches", rsp_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
